// ----- rtl/core/box_corner_segment_crossing_unit_macros.svh -----
// assertion helpers for the box corner crossing unit
`ifndef BOX_CORNER_SEGMENT_CROSSING_UNIT_MACROS_SVH
`define BOX_CORNER_SEGMENT_CROSSING_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define BCSC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bcsc assertion failed");

// next-cycle implication, disabled while reset is low
`define BCSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bcsc assertion failed");

`endif

// ----- rtl/core/bcsc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package bcsc_pkg;

    localparam int COORD_W   = 24;
    localparam int DIFF_W    = 25;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    localparam int ROT_W     = 19;
    localparam int ANG_W     = 18;
    localparam int STEPS     = 15;
    localparam int STEPS_PER_STAGE = 5;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUND_IDX  = 2'd2;

    localparam logic [15:0] RST_BOX_WIDTH  = 16'd2560;
    localparam logic [15:0] RST_BOX_LENGTH = 16'd7680;
    localparam logic [7:0]  RST_BOUND_IDX  = 8'd4;

    localparam logic signed [ROT_W-1:0] CORDIC_GAIN = 19'sd19899;

    typedef logic signed [ANG_W-1:0] t_ang_tab [STEPS];
    localparam t_ang_tab CORDIC_ANGLE = '{
        18'sd8192, 18'sd4836, 18'sd2555, 18'sd1297, 18'sd651, 18'sd326, 18'sd163,
        18'sd81, 18'sd41, 18'sd20, 18'sd10, 18'sd5, 18'sd3, 18'sd1, 18'sd1
    };

    typedef struct packed {
        logic signed [ROT_W-1:0] x;
        logic signed [ROT_W-1:0] y;
        logic signed [ANG_W-1:0] z;
    } t_rot;

    // segment differences carried down the pipeline
    typedef struct packed {
        logic signed [DIFF_W-1:0] a;   // x1 - x2
        logic signed [DIFF_W-1:0] b;   // y1 - y2
        logic signed [DIFF_W-1:0] e;   // x1 - cx
        logic signed [DIFF_W-1:0] f;   // y1 - cy
    } t_seg;

    typedef struct packed {
        logic skip;
        logic last;
    } t_flags;

    // one rotation step of the cordic
    function automatic t_rot cordic_step(input t_rot v, input int i);
        t_rot r;
        logic signed [ROT_W-1:0] dx;
        logic signed [ROT_W-1:0] dy;
        dx = v.y >>> i;
        dy = v.x >>> i;
        if (!v.z[ANG_W-1]) begin
            r.x = v.x - dx;
            r.y = v.y + dy;
            r.z = v.z - CORDIC_ANGLE[i];
        end else begin
            r.x = v.x + dx;
            r.y = v.y - dy;
            r.z = v.z + CORDIC_ANGLE[i];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/bcsc_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface bcsc_seg_if;
    import bcsc_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [COORD_W-1:0]  centre_x;
    logic signed [COORD_W-1:0]  centre_y;
    logic [15:0]                heading;
    logic                       check_bound;
    logic signed [COORD_W-1:0]  seg_x1;
    logic signed [COORD_W-1:0]  seg_y1;
    logic signed [COORD_W-1:0]  seg_x2;
    logic signed [COORD_W-1:0]  seg_y2;
    logic                       last_segment;
    modport source (output valid, centre_x, centre_y, heading, check_bound,
                    seg_x1, seg_y1, seg_x2, seg_y2, last_segment, input ready);
    modport sink   (input valid, centre_x, centre_y, heading, check_bound,
                    seg_x1, seg_y1, seg_x2, seg_y2, last_segment, output ready);
endinterface

interface bcsc_res_if;
    logic valid;
    logic ready;
    logic collided;
    modport source (output valid, collided, input ready);
    modport sink   (input valid, collided, output ready);
endinterface

interface bcsc_cfg_if;
    import bcsc_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/box_corner_segment_crossing_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// channel   dir  handshake      payload
// i_seg     in   valid/ready    centre, heading, check_bound, segment ends, last_segment
// o_res     out  valid/ready    collided, one per list on its last segment
// i_cfg     in   valid/ready    index (0 width, 1 length, 2 boundary), data
//
// one segment per cycle while no waiting result stalls; from acceptance to result the stages are
// (fold, three cordic stages of five steps, corner products, corner sums,
// crossing products, subtracts, compares, result register)
// synchronous active-low reset clears list counter, hit flag and valid bits and loads
// the configuration defaults; a stalled result freezes the whole pipeline, nothing lost
module box_corner_segment_crossing_unit import bcsc_pkg::*; #(
    parameter int MAX_SEGMENTS = 256
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    bcsc_seg_if.sink    i_seg,
    bcsc_res_if.source  o_res,
    bcsc_cfg_if.sink    i_cfg
);

    localparam int CW   = $clog2(MAX_SEGMENTS + 1);
    localparam int CMPW = (CW > 8) ? CW : 8;
    localparam int PW   = ROT_W + 17;
    localparam int SW   = PW + 2;
    localparam int VW   = 21;
    localparam int MW   = DIFF_W + VW;
    localparam int UW   = 2 * DIFF_W;
    localparam int DW   = MW + 1;
    localparam int NW   = UW + 1;

    logic [15:0] r_width;
    logic [15:0] r_length;
    logic [7:0]  r_bidx;
    logic [CW-1:0] r_cnt;
    logic        r_hit;
    logic        r_ovld;
    logic        r_ocol;

    logic        en;
    logic        acc;

    logic        r_vld [1:9];
    t_flags      r_flg [1:9];
    t_seg        r_seg [1:6];

    logic signed [ROT_W-1:0] cos_v;
    logic signed [ROT_W-1:0] sin_v;

    logic signed [PW-1:0] r_ls, r_wc, r_lc, r_ws;
    logic signed [VW-1:0] r_vx [4];
    logic signed [VW-1:0] r_vy [4];
    logic signed [VW-1:0] n_vx [4];
    logic signed [VW-1:0] n_vy [4];
    logic signed [MW-1:0] r_m1 [4];
    logic signed [MW-1:0] r_m2 [4];
    logic signed [MW-1:0] r_m3 [4];
    logic signed [MW-1:0] r_m4 [4];
    logic signed [UW-1:0] r_be, r_af;
    logic signed [DW-1:0] r_den [4];
    logic signed [DW-1:0] r_tn [4];
    logic signed [NW-1:0] r_un;
    logic        r_ihit;
    logic        n_ihit;
    logic        n_skip;
    logic        n_hit;

    // pipeline advances unless a result is waiting and not taken
    assign en  = !r_ovld || o_res.ready;
    assign acc = i_seg.valid && en;
    assign i_seg.ready = en;
    assign i_cfg.ready = 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RST_BOX_WIDTH;
            r_length <= RST_BOX_LENGTH;
            r_bidx   <= RST_BOUND_IDX;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_BOX_WIDTH:  r_width  <= i_cfg.data;
                CFG_BOX_LENGTH: r_length <= i_cfg.data;
                CFG_BOUND_IDX:  r_bidx   <= i_cfg.data[7:0];
                default: ;
            endcase
        end
    end

    // boundary skip against the current list position
    assign n_skip = !i_seg.check_bound && (CMPW'(r_cnt) == CMPW'(r_bidx));

    // list position counter, saturating
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (acc) begin
            if (i_seg.last_segment) begin
                r_cnt <= '0;
            end else if (r_cnt < CW'(MAX_SEGMENTS)) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    bcsc_cordic u_cordic (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_heading (i_seg.heading),
        .o_cos     (cos_v),
        .o_sin     (sin_v)
    );

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 1; i <= 9; i++) r_vld[i] <= 1'b0;
        end else if (en) begin
            r_vld[1] <= i_seg.valid;
            for (int i = 2; i <= 9; i++) r_vld[i] <= r_vld[i - 1];
        end
    end

    // segment differences and flags down the line
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_flg[1] <= '{skip: n_skip, last: i_seg.last_segment};
            for (int i = 2; i <= 9; i++) r_flg[i] <= r_flg[i - 1];
            r_seg[1].a <= DIFF_W'(i_seg.seg_x1) - DIFF_W'(i_seg.seg_x2);
            r_seg[1].b <= DIFF_W'(i_seg.seg_y1) - DIFF_W'(i_seg.seg_y2);
            r_seg[1].e <= DIFF_W'(i_seg.seg_x1) - DIFF_W'(i_seg.centre_x);
            r_seg[1].f <= DIFF_W'(i_seg.seg_y1) - DIFF_W'(i_seg.centre_y);
            for (int i = 2; i <= 6; i++) r_seg[i] <= r_seg[i - 1];
        end
    end

    // corner sums with rounding half up
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            logic signed [SW-1:0] sx;
            logic signed [SW-1:0] sy;
            logic signed [SW-1:0] pl;
            logic signed [SW-1:0] pw;
            logic signed [SW-1:0] ql;
            logic signed [SW-1:0] qw;
            pl = SW'(r_ls);
            pw = SW'(r_wc);
            ql = SW'(r_lc);
            qw = SW'(r_ws);
            if (k < 2) begin
                sx = pl;
                sy = -ql;
            end else begin
                sx = -pl;
                sy = ql;
            end
            if (k == 1 || k == 2) begin
                sx = sx + pw;
                sy = sy + qw;
            end else begin
                sx = sx - pw;
                sy = sy - qw;
            end
            sx = sx + SW'(32768);
            sy = sy + SW'(32768);
            n_vx[k] = sx[16 +: VW];
            n_vy[k] = sy[16 +: VW];
        end
    end

    // crossing decision per corner
    always_comb begin
        n_ihit = 1'b0;
        for (int k = 0; k < 4; k++) begin
            logic signed [NW-1:0] dn;
            dn = NW'(r_den[k]);
            if (!r_den[k][DW-1] && r_den[k] != '0) begin
                if (r_tn[k] > 0 && r_tn[k] < r_den[k] && r_un > 0 && r_un < dn) begin
                    n_ihit = 1'b1;
                end
            end else if (r_den[k][DW-1]) begin
                if (r_tn[k] < 0 && r_tn[k] > r_den[k] && r_un < 0 && r_un > dn) begin
                    n_ihit = 1'b1;
                end
            end
        end
        if (r_flg[8].skip) n_ihit = 1'b0;
    end

    // arithmetic stages
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ls <= $signed({1'b0, r_length}) * sin_v;
            r_wc <= $signed({1'b0, r_width}) * cos_v;
            r_lc <= $signed({1'b0, r_length}) * cos_v;
            r_ws <= $signed({1'b0, r_width}) * sin_v;
            for (int k = 0; k < 4; k++) begin
                r_vx[k] <= n_vx[k];
                r_vy[k] <= n_vy[k];
                r_m1[k] <= r_seg[6].b * r_vx[k];
                r_m2[k] <= r_seg[6].a * r_vy[k];
                r_m3[k] <= r_seg[6].f * r_vx[k];
                r_m4[k] <= r_seg[6].e * r_vy[k];
                r_den[k] <= DW'(r_m1[k]) - DW'(r_m2[k]);
                r_tn[k]  <= DW'(r_m3[k]) - DW'(r_m4[k]);
            end
            r_be <= r_seg[6].b * r_seg[6].e;
            r_af <= r_seg[6].a * r_seg[6].f;
            r_un <= NW'(r_be) - NW'(r_af);
            r_ihit <= n_ihit;
        end
    end

    // hit accumulation over the list and result register
    assign n_hit = r_hit || r_ihit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit  <= 1'b0;
            r_ovld <= 1'b0;
        end else if (en) begin
            r_ovld <= r_vld[9] && r_flg[9].last;
            if (r_vld[9]) begin
                r_hit <= r_flg[9].last ? 1'b0 : n_hit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ocol <= n_hit;
        end
    end

    assign o_res.valid    = r_ovld;
    assign o_res.collided = r_ocol;

endmodule
`default_nettype wire

// ----- rtl/core/bcsc_cordic.sv -----
`timescale 1ns / 1ps
`default_nettype none
module bcsc_cordic import bcsc_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_en,
    input  wire logic [15:0]             i_heading,
    output logic signed [ROT_W-1:0]      o_cos,
    output logic signed [ROT_W-1:0]      o_sin
);

    t_rot r_rot [1:3];
    logic r_flip [1:3];
    logic signed [ROT_W-1:0] r_cos;
    logic signed [ROT_W-1:0] r_sin;

    logic signed [ANG_W-1:0] n_z0;
    logic n_flip0;
    t_rot n_rot [2:4];

    // fold the heading into (-90, 90] degrees
    always_comb begin
        logic signed [ANG_W-1:0] z;
        z = ANG_W'($signed(i_heading));
        n_flip0 = 1'b0;
        n_z0 = z;
        if (z > 18'sd16384) begin
            n_z0 = z - 18'sd32768;
            n_flip0 = 1'b1;
        end else if (z <= -18'sd16384) begin
            n_z0 = z + 18'sd32768;
            n_flip0 = 1'b1;
        end
    end

    // five rotation steps per stage
    always_comb begin
        for (int s = 0; s < 3; s++) begin
            t_rot v;
            v = r_rot[s + 1];
            for (int k = 0; k < STEPS_PER_STAGE; k++) begin
                v = cordic_step(v, s * STEPS_PER_STAGE + k);
            end
            n_rot[s + 2] = v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rot[1] <= '{x: CORDIC_GAIN, y: '0, z: n_z0};
            r_flip[1] <= n_flip0;
            r_rot[2] <= n_rot[2];
            r_flip[2] <= r_flip[1];
            r_rot[3] <= n_rot[3];
            r_flip[3] <= r_flip[2];
            r_cos <= r_flip[3] ? -n_rot[4].x : n_rot[4].x;
            r_sin <= r_flip[3] ? -n_rot[4].y : n_rot[4].y;
        end
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;

endmodule
`default_nettype wire

// ----- rtl/core/bcsc_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "box_corner_segment_crossing_unit_macros.svh"
module bcsc_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic i_in_ready,
    input wire logic i_out_valid,
    input wire logic i_out_ready,
    input wire logic i_out_collided,
    input wire logic i_cfg_ready
);

    // a waiting result holds its value
    `BCSC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_collided))

    // input side only stalls behind a waiting result
    `BCSC_ASSERT_IMPL(a_stall_cause, i_clk, i_rst_n, !i_in_ready, i_out_valid && !i_out_ready)

    // no pending result means input is open
    `BCSC_ASSERT_IMPL(a_open_idle, i_clk, i_rst_n, !i_out_valid, i_in_ready)

    // configuration is never refused
    `BCSC_ASSERT_IMPL(a_cfg_open, i_clk, i_rst_n, i_in_valid || !i_in_valid, i_cfg_ready)

endmodule

bind box_corner_segment_crossing_unit bcsc_checker u_bcsc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_seg.valid),
    .i_in_ready     (i_seg.ready),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_out_collided (o_res.collided),
    .i_cfg_ready    (i_cfg.ready)
);
`default_nettype wire
